// ----- sv/qpd_pkg.sv -----
`default_nettype none

package qpd_pkg;

  // Width of the running decoded-byte count (saturating)
  localparam int COUNT_WIDTH = 16;

  // Depth of the command queue between the front and back parts
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } qpd_in_t;

  typedef struct packed {
    logic [7:0]             out_byte;
    kind_t                  kind;
    logic [COUNT_WIDTH-1:0] decoded_count;
    logic                   out_last;
  } qpd_out_t;

  // One decoded request's worth of work: an optional data byte, then an
  // optional end-of-message result. The count is the one both carry.
  typedef struct packed {
    logic                   has_data;
    logic                   has_end;
    logic                   end_err;
    logic [7:0]             data_byte;
    logic [COUNT_WIDTH-1:0] count;
  } qpd_cmd_t;

endpackage

`default_nettype wire

// ----- sv/qpd_front.sv -----
`default_nettype none

module qpd_front import qpd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data,
  input  wire logic     push,
  input  wire qpd_in_t  in_item,
  input  wire logic     q_full,
  output logic          q_push,
  output qpd_cmd_t      q_cmd
);

  typedef enum logic [4:0] {
    PH_TEXT   = 5'b00001,
    PH_EQ     = 5'b00010,
    PH_HIGH   = 5'b00100,
    PH_SPACES = 5'b01000,
    PH_CR     = 5'b10000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [3:0]             high_digit, high_digit_next;
  logic [COUNT_WIDTH-1:0] byte_count, byte_count_next;
  logic                   discarding, discarding_next;
  logic                   underscore_as_space;

  logic                   accept;
  logic [7:0]             b;
  logic                   last;
  logic                   is_hex, is_sp, is_brk;
  logic [3:0]             hex_val;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   emit_data, fin, fin_err;
  logic [7:0]             data_byte;

  assign accept = push && !q_full;
  assign b      = in_item.in_byte;
  assign last   = in_item.in_last;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      hex_val = 4'(b - 8'h30);
    end else if (b inside {[8'h41:8'h46]}) begin
      hex_val = 4'(b - 8'h37);
    end else if (b inside {[8'h61:8'h66]}) begin
      hex_val = 4'(b - 8'h57);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_sp  = (b == CH_SPACE) || (b == CH_TAB);
  assign is_brk = (b == CH_CR) || (b == CH_LF);

  assign count_inc = (byte_count == {COUNT_WIDTH{1'b1}}) ? byte_count
                                                         : byte_count + 1'b1;

  always_comb begin
    phase_next      = phase;
    high_digit_next = high_digit;
    byte_count_next = byte_count;
    discarding_next = discarding;
    emit_data       = 1'b0;
    data_byte       = b;
    fin             = 1'b0;
    fin_err         = 1'b0;

    if (discarding) begin
      if (last) begin
        discarding_next = 1'b0;
      end
    end else begin
      case (phase)
        PH_EQ: begin
          if (b == CH_NUL) begin
            fin = 1'b1;
          end else if (is_hex) begin
            high_digit_next = hex_val;
            phase_next      = PH_HIGH;
            fin             = last;
            fin_err         = 1'b1;
          end else if (is_sp) begin
            phase_next = PH_SPACES;
            fin        = last;
            fin_err    = 1'b1;
          end else if (is_brk) begin
            phase_next = (b == CH_CR && !last) ? PH_CR : PH_TEXT;
            fin        = last;
          end else begin
            fin     = 1'b1;
            fin_err = 1'b1;
          end
        end
        PH_HIGH: begin
          if (is_hex) begin
            emit_data       = 1'b1;
            data_byte       = {high_digit, hex_val};
            phase_next      = PH_TEXT;
            high_digit_next = 4'd0;
            fin             = last;
          end else begin
            fin     = 1'b1;
            fin_err = 1'b1;
          end
        end
        PH_SPACES: begin
          if (is_sp) begin
            fin     = last;
            fin_err = 1'b1;
          end else if (is_brk) begin
            phase_next = (b == CH_CR && !last) ? PH_CR : PH_TEXT;
            fin        = last;
          end else begin
            fin     = 1'b1;
            fin_err = 1'b1;
          end
        end
        default: begin
          // plain text, and the byte after a soft-break CR
          phase_next = PH_TEXT;
          if (phase == PH_CR && b == CH_LF) begin
            fin = last;
          end else if (b == CH_NUL) begin
            fin = 1'b1;
          end else if (b == CH_EQ) begin
            phase_next = PH_EQ;
            fin        = last;
          end else begin
            emit_data = 1'b1;
            if (underscore_as_space && b == CH_UNDER) begin
              data_byte = CH_SPACE;
            end
            fin = last;
          end
        end
      endcase

      if (emit_data) begin
        byte_count_next = count_inc;
      end
      if (fin) begin
        phase_next      = PH_TEXT;
        high_digit_next = 4'd0;
        byte_count_next = '0;
        discarding_next = !last;
      end
    end
  end

  assign q_push         = accept && (emit_data || fin);
  assign q_cmd.has_data = emit_data;
  assign q_cmd.has_end  = fin;
  assign q_cmd.end_err  = fin_err;
  assign q_cmd.data_byte = data_byte;
  assign q_cmd.count    = emit_data ? count_inc : byte_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_TEXT;
      high_digit          <= 4'd0;
      byte_count          <= '0;
      discarding          <= 1'b0;
      underscore_as_space <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        underscore_as_space <= cfg_wr_data;
      end
      if (accept) begin
        phase      <= phase_next;
        high_digit <= high_digit_next;
        byte_count <= byte_count_next;
        discarding <= discarding_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/qpd_fifo.sv -----
`default_nettype none

module qpd_fifo import qpd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr_en,
  input  wire qpd_cmd_t wr_data,
  output logic          full,
  input  wire logic     rd_en,
  output qpd_cmd_t      rd_data,
  output logic          empty
);

  qpd_cmd_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_wr, do_rd;

  assign full    = (fill == QCNT_W'(QDEPTH));
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/qpd_back.sv -----
`default_nettype none

module qpd_back import qpd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire qpd_cmd_t cmd,
  input  wire logic     cmd_avail,
  output logic          cmd_pop,
  input  wire logic     pop,
  output logic          empty,
  output qpd_out_t      out_item
);

  logic     out_valid;
  logic     pend_end;
  qpd_out_t pend_item;
  logic     out_free;
  qpd_out_t end_item;
  qpd_out_t data_item;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  // a command is taken only when no end result of the previous one waits
  assign cmd_pop  = out_free && !pend_end && cmd_avail;

  always_comb begin
    end_item.out_byte      = 8'h00;
    end_item.kind          = cmd.end_err ? KIND_ERROR : KIND_DONE;
    end_item.decoded_count = cmd.count;
    end_item.out_last      = 1'b1;
    data_item.out_byte      = cmd.data_byte;
    data_item.kind          = KIND_DATA;
    data_item.decoded_count = cmd.count;
    data_item.out_last      = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_free && pend_end) begin
      out_item <= pend_item;
    end else if (cmd_pop) begin
      out_item  <= cmd.has_data ? data_item : end_item;
      pend_item <= end_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_end  <= 1'b0;
    end else if (out_free) begin
      if (pend_end) begin
        out_valid <= 1'b1;
        pend_end  <= 1'b0;
      end else if (cmd_avail) begin
        out_valid <= 1'b1;
        pend_end  <= cmd.has_data && cmd.has_end;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/quoted_printable_decoder_core.sv -----
`default_nettype none

// Quoted-printable decoder core.
//
// Input channel: one encoded byte per request with a last flag, offered on
// in_item with push; taken at an edge where push is high and full is low.
// Output channel: results on out_item while empty is low, taken with pop.
// Each result is a decoded data byte, a done marker carrying the decoded
// count, or an error marker; done and error carry out_last and close the
// message. After an error the host throws away that message's data.
// Configuration: cfg_wr_en/cfg_wr_data write underscore_as_space, which
// turns '_' into a space; write it only while the block is idle.
//
// Timing: a request is decoded in the cycle it is taken (front part) and
// lands in a four-entry command queue; the back part moves it from the
// queue to the output register once that register is free. One request
// per cycle is taken while full is low. A request yielding both a data
// byte and a done marker fills the output register twice, which is what
// the queue soaks up.
// Reset clears decoder state, the register, the queue and the output.
// When the receiver holds off pop, the output register and then the queue
// fill, and full rises; nothing is lost.

module quoted_printable_decoder_core import qpd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data,
  input  wire logic     push,
  input  wire qpd_in_t  in_item,
  output logic          full,
  input  wire logic     pop,
  output logic          empty,
  output qpd_out_t      out_item
);

  logic     q_push;
  qpd_cmd_t q_cmd;
  logic     q_pop;
  qpd_cmd_t q_head;
  logic     q_empty;

  // front: byte classification and escape state machine
  qpd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .in_item     (in_item),
    .q_full      (full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  // decoupling queue; its full flag is the input channel's back-pressure
  qpd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_cmd),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  // back: splits each command into results and holds the output register
  qpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_head),
    .cmd_avail (!q_empty),
    .cmd_pop   (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- sv/qpd_checker.sv -----
`default_nettype none

module qpd_checker import qpd_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     full,
  input wire logic     pop,
  input wire logic     empty,
  input wire qpd_out_t out_item
);

  // a waiting result holds until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("result changed while waiting");

  // only done and error close a message
  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((out_item.kind == KIND_DATA) == !out_item.out_last))
    else $error("out_last does not match kind");

  // end markers carry no byte
  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.kind != KIND_DATA) |-> (out_item.out_byte == 8'h00))
    else $error("non-zero byte on end marker");

  // reset leaves both channels idle
  a_reset: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("channels not idle after reset");

endmodule

bind quoted_printable_decoder_core qpd_checker u_checker (.*);

`default_nettype wire

// ----- dv/qpd_decode_monitor.sv -----
module qpd_decode_monitor import qpd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data,
  input  logic     push,
  input  logic     full,
  input  qpd_in_t  in_item,
  input  logic     pop,
  input  logic     empty,
  input  qpd_out_t out_item,
  output int       mismatches,
  output int       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    TEXT_RUN,
    SAW_EQUALS,
    SAW_HIGH,
    IN_BLANKS,
    SAW_CR
  } qp_phase_t;

  logic                   underscore_mode;
  qp_phase_t              phase_q;
  logic [3:0]             hi_digit;
  logic [COUNT_WIDTH-1:0] byte_total;
  logic                   dropping;
  qpd_out_t               decoded_results[$];

  function void post_result(logic [7:0] b, kind_t k, logic l);
    qpd_out_t r;
    r.out_byte      = b;
    r.kind          = k;
    r.decoded_count = byte_total;
    r.out_last      = l;
    decoded_results.push_back(r);
  endfunction

  // done/error closes the message; not last means the tail gets dropped
  function void close_message(kind_t k, logic last_in);
    post_result(8'h00, k, 1'b1);
    phase_q     = TEXT_RUN;
    hi_digit    = 4'd0;
    byte_total  = '0;
    dropping    = !last_in;
  endfunction

  function void emit_byte(logic [7:0] b);
    if (byte_total != '1) byte_total = byte_total + 1'b1;
    post_result(b, KIND_DATA, 1'b0);
  endfunction

  function void take_plain(logic [7:0] b, logic last_in);
    logic [7:0] c;
    c = b;
    if (c == CH_NUL) begin
      close_message(KIND_DONE, last_in);
    end else if (c == CH_EQ) begin
      phase_q = SAW_EQUALS;
      if (last_in) close_message(KIND_DONE, last_in);
    end else begin
      if (underscore_mode && c == CH_UNDER) c = CH_SPACE;
      emit_byte(c);
      if (last_in) close_message(KIND_DONE, last_in);
    end
  endfunction

  function void take_break(logic [7:0] b, logic last_in);
    if (b == CH_CR && !last_in) begin
      phase_q = SAW_CR;
    end else begin
      phase_q = TEXT_RUN;
      if (last_in) close_message(KIND_DONE, last_in);
    end
  endfunction

  // One encoded byte in, zero to two results queued
  function void qp_decode(logic [7:0] b, logic last_in);
    logic       is_hex;
    logic       is_blank;
    logic       is_break;
    logic [3:0] nib;
    is_hex   = 1'b1;
    is_blank = (b == CH_SPACE) || (b == CH_TAB);
    is_break = (b == CH_CR) || (b == CH_LF);
    if (b >= "0" && b <= "9") nib = 4'(b - "0");
    else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
    else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
    else begin
      is_hex = 1'b0;
      nib    = 4'd0;
    end

    if (dropping) begin
      if (last_in) dropping = 1'b0;
      return;
    end

    case (phase_q)
      SAW_EQUALS: begin
        if (b == CH_NUL) close_message(KIND_DONE, last_in);
        else if (is_hex) begin
          hi_digit = nib;
          phase_q  = SAW_HIGH;
          if (last_in) close_message(KIND_ERROR, last_in);
        end else if (is_blank) begin
          phase_q = IN_BLANKS;
          if (last_in) close_message(KIND_ERROR, last_in);
        end else if (is_break) take_break(b, last_in);
        else close_message(KIND_ERROR, last_in);
      end
      SAW_HIGH: begin
        if (is_hex) begin
          emit_byte({hi_digit, nib});
          phase_q  = TEXT_RUN;
          hi_digit = 4'd0;
          if (last_in) close_message(KIND_DONE, last_in);
        end else begin
          close_message(KIND_ERROR, last_in);
        end
      end
      IN_BLANKS: begin
        if (is_blank) begin
          if (last_in) close_message(KIND_ERROR, last_in);
        end else if (is_break) take_break(b, last_in);
        else close_message(KIND_ERROR, last_in);
      end
      SAW_CR: begin
        phase_q = TEXT_RUN;
        if (b == CH_LF) begin
          if (last_in) close_message(KIND_DONE, last_in);
        end else begin
          take_plain(b, last_in);
        end
      end
      default: begin
        phase_q = TEXT_RUN;
        take_plain(b, last_in);
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    qpd_out_t want;
    if (rst) begin
      underscore_mode = 1'b0;
      phase_q         = TEXT_RUN;
      hi_digit        = 4'd0;
      byte_total      = '0;
      dropping        = 1'b0;
      decoded_results.delete();
    end else begin
      // results leave before this edge's request is decoded
      if (pop && !empty) begin
        if (decoded_results.size() == 0) begin
          mismatches <= mismatches + 1;
          $display("%0t ns: expected no result, got byte %02h kind %0d count %0d last %b",
                   $time, out_item.out_byte, out_item.kind, out_item.decoded_count,
                   out_item.out_last);
        end else begin
          want = decoded_results.pop_front();
          if (out_item !== want) mismatches <= mismatches + 1;
          if (out_item.out_byte !== want.out_byte)
            $display("%0t ns: out_byte expected %02h, got %02h",
                     $time, want.out_byte, out_item.out_byte);
          if (out_item.kind !== want.kind)
            $display("%0t ns: kind expected %0d, got %0d", $time, want.kind, out_item.kind);
          if (out_item.decoded_count !== want.decoded_count)
            $display("%0t ns: decoded_count expected %0d, got %0d",
                     $time, want.decoded_count, out_item.decoded_count);
          if (out_item.out_last !== want.out_last)
            $display("%0t ns: out_last expected %b, got %b",
                     $time, want.out_last, out_item.out_last);
        end
      end
      if (cfg_wr_en) underscore_mode = cfg_wr_data;
      if (push && !full) qp_decode(in_item.in_byte, in_item.in_last);
    end
    outstanding <= decoded_results.size();
  end

endmodule

// ----- dv/tb_quoted_printable_decoder_core.sv -----
module tb_quoted_printable_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import qpd_pkg::*;

  // Cycles with no request or result taken before the run is called hung.
  // Worst honest stretch is a sender gap, a receiver gap and a config pause,
  // all well under this.
  localparam int WATCHDOG_LIMIT = 1000;
  // Front decodes on acceptance, back registers from the queue; a request that
  // yields nothing may still be in flight when the last result has gone.
  localparam int QUIET_CYCLES   = 12;
  // Requests per random phase
  localparam int PHASE_REQUESTS = 480;

  logic     clk         = 1'b0;
  logic     rst         = 1'b1;
  logic     cfg_wr_en   = 1'b0;
  logic     cfg_wr_data = 1'b0;
  logic     push        = 1'b0;
  qpd_in_t  in_item     = '0;
  logic     full;
  logic     pop         = 1'b0;
  logic     empty;
  qpd_out_t out_item;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  // Remaining zero-gap requests in the current burst, per side
  int send_calm   = 0;
  int pop_calm    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quoted_printable_decoder_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .in_item     (in_item),
    .full        (full),
    .pop         (pop),
    .empty       (empty),
    .out_item    (out_item)
  );

  qpd_decode_monitor i_monitor (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .full        (full),
    .in_item     (in_item),
    .pop         (pop),
    .empty       (empty),
    .out_item    (out_item),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Gap before the next request: mostly drawn at random, with occasional
  // bursts where the side never idles.
  function automatic int next_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return "0" + 8'(v);
    if ($urandom_range(0, 1) == 0) return "A" + 8'(v - 4'd10);
    return "a" + 8'(v - 4'd10);
  endfunction

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB;
  endfunction

  // Plain text byte: never '=' or NUL, heavy on underscores and printables,
  // but the full 1..255 range turns up too.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       c = CH_UNDER;
      1:       c = 8'($urandom_range(1, 255));
      default: c = 8'($urandom_range(33, 126));
    endcase
    if (c == CH_EQ) c = CH_UNDER;
    return c;
  endfunction

  // Offer one request after a random gap and hold it until taken. push is
  // only dropped when there is a gap, so back-to-back requests keep it high.
  task automatic send_request(logic [7:0] b, logic l);
    int gap;
    gap = next_gap(send_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item.in_byte <= b;
    in_item.in_last <= l;
    push            <= 1'b1;
    do @(posedge clk); while (full);
  endtask

  // Stop offering, let every predicted result drain, then allow for
  // requests still in flight that produce nothing.
  task automatic wait_quiet();
    push <= 1'b0;
    repeat (2) @(posedge clk);   // outstanding is registered, so it lags the edge
    while (outstanding != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_underscore(logic on);
    wait_quiet();
    cfg_wr_data <= on;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // One random message. Mostly well-formed tokens (text, hex escapes, soft
  // breaks) so the decoder gets past the escape states; some broken escapes
  // and stray NULs, and now and then a tail cut off inside an escape.
  // sent returns how many requests went out, dropped ones included.
  task automatic send_message(output int sent);
    logic [7:0] text[$];
    int         tokens;
    int         pick;
    int         sel;
    tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 9);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        text.push_back(plain_char());
      end else if (pick < 68) begin
        text.push_back(CH_EQ);
        text.push_back(hex_char(4'($urandom_range(0, 15))));
        text.push_back(hex_char(4'($urandom_range(0, 15))));
      end else if (pick < 83) begin
        // soft break: optional blanks then CRLF, LF or a lone CR
        text.push_back(CH_EQ);
        repeat ($urandom_range(0, 3)) text.push_back(blank_char());
        sel = $urandom_range(0, 2);
        if (sel != 1) text.push_back(CH_CR);
        if (sel != 2) text.push_back(CH_LF);
      end else if (pick < 95) begin
        // broken escape: any byte where a hex digit or break should be
        text.push_back(CH_EQ);
        sel = $urandom_range(0, 2);
        if (sel == 1) text.push_back(hex_char(4'($urandom_range(0, 15))));
        else if (sel == 2) text.push_back(blank_char());
        text.push_back(8'($urandom_range(0, 255)));
      end else begin
        text.push_back(CH_NUL);
      end
    end
    // message flagged last part way through an escape
    if ($urandom_range(0, 4) == 0) begin
      text.push_back(CH_EQ);
      sel = $urandom_range(0, 4);
      if (sel == 1) text.push_back(hex_char(4'($urandom_range(0, 15))));
      else if (sel == 2) text.push_back(blank_char());
      else if (sel == 3) text.push_back(CH_CR);
      else if (sel == 4) begin
        text.push_back(blank_char());
        text.push_back(CH_LF);
      end
    end
    if (text.size() == 0) text.push_back(plain_char());

    foreach (text[i]) begin
      send_request(text[i], i == text.size() - 1);
    end
    sent = text.size();
  endtask

  // Watchdog: any request or result taken restarts the count
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall before each result, pop held until one is taken.
  // pop is only lowered when a stall is drawn.
  initial begin : result_side
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = next_gap(pop_calm);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  initial begin : stimulus
    int sent;
    int total;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // --- directed, underscores left alone ---
    write_underscore(1'b0);
    send_request(CH_UNDER, 1'b0);                 // kept as '_'
    send_request(CH_EQ, 1'b0);                    // =aF -> 0xAF, mixed case
    send_request("a", 1'b0);
    send_request("F", 1'b0);
    send_request(CH_EQ, 1'b0);                    // soft break on a lone CR
    send_request(CH_CR, 1'b0);
    send_request("x", 1'b0);                      // ...so x is plain text
    send_request(CH_EQ, 1'b0);                    // blanks then CRLF
    send_request(CH_SPACE, 1'b0);
    send_request(CH_TAB, 1'b0);
    send_request(CH_CR, 1'b0);
    send_request(CH_LF, 1'b0);
    send_request(CH_EQ, 1'b0);                    // first digit, then non-hex
    send_request("4", 1'b0);
    send_request("g", 1'b0);                      // error, tail dropped
    send_request(CH_NUL, 1'b1);                   // last ends the drop quietly
    send_request(CH_EQ, 1'b1);                    // trailing '=': done, no error
    send_request(CH_EQ, 1'b0);                    // blank flagged last: error
    send_request(CH_SPACE, 1'b1);
    send_request(CH_EQ, 1'b0);                    // '=' then NUL: done, then drop
    send_request(CH_NUL, 1'b0);
    send_request(8'hFF, 1'b1);                    // top byte, swallowed by the drop
    send_request(CH_EQ, 1'b0);                    // first digit flagged last
    send_request("7", 1'b1);
    send_request(CH_EQ, 1'b0);                    // junk after '='
    send_request("G", 1'b0);
    send_request("z", 1'b1);
    send_request(8'hFF, 1'b1);                    // data on last: data then done

    // --- underscore decoding on ---
    write_underscore(1'b1);
    send_request(CH_UNDER, 1'b0);
    send_request("a", 1'b0);
    send_request(CH_UNDER, 1'b1);

    total = 0;
    while (total < PHASE_REQUESTS) begin
      send_message(sent);
      total += sent;
    end

    write_underscore(1'b0);
    total = 0;
    while (total < PHASE_REQUESTS) begin
      send_message(sent);
      total += sent;
    end

    write_underscore(1'b1);
    total = 0;
    while (total < PHASE_REQUESTS) begin
      send_message(sent);
      total += sent;
    end

    wait_quiet();
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
